// ----- rtl/rtpmhp_pkg.sv -----
package rtpmhp_pkg;

    // Packet length bound; longer packets are flagged invalid
    localparam int unsigned MAX_PACKET_BYTES = 2048;

    localparam int unsigned POS_W  = 12;           // byte index, saturating
    localparam int unsigned SIZE_W = POS_W + 1;    // byte count of a packet
    localparam int unsigned HDR_W  = 19;           // header end incl. extension body
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [POS_W-1:0] POS_MAX = '1;

    localparam int unsigned BASE_HDR_BYTES   = 12;
    localparam int unsigned EXT_HDR_BYTES    = 4;
    localparam int unsigned MIN_PACKET_BYTES = 12;
    localparam int unsigned SSRC_FIRST_POS   = 8;
    localparam int unsigned SSRC_LAST_POS    = 11;
    localparam int unsigned EXT_LEN_HI_OFS   = 2;
    localparam int unsigned EXT_LEN_LO_OFS   = 3;

    localparam logic [1:0] RTP_VERSION = 2'd2;
    localparam logic [6:0] PT_CTRL_LO  = 7'd72;
    localparam logic [6:0] PT_CTRL_HI  = 7'd76;

    // Per-packet summary handed from the byte front end to the checker
    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic              too_long;
        logic [7:0]        first_byte;
        logic [6:0]        ptype;
        logic [31:0]       ssrc;
        logic [15:0]       ext_words;
        logic [7:0]        last_byte;
        logic              aead_mode;
    } summary_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    typedef struct packed {
        logic        status;
        logic        media_ok;
        logic [11:0] payload_offset;
        logic [11:0] payload_length;
        logic [6:0]  aad_length;
        logic [17:0] ext_body_length;
        logic [31:0] sync_source;
    } result_t;

endpackage

// ----- rtl/rtpmhp_front.sv -----
module rtpmhp_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 byte_acc,
    input  logic [7:0]           pkt_byte,
    input  logic                 end_of_packet,
    input  logic                 aead_mode,
    output logic                 push,
    output rtpmhp_pkg::summary_t push_data
);
    import rtpmhp_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       first_reg, first_next;
    logic [6:0]       ptype_reg, ptype_next;
    logic [31:0]      ssrc_reg, ssrc_next;
    logic [15:0]      ext_reg, ext_next;
    logic             too_long_reg, too_long_next;

    logic [7:0]       first_upd;
    logic [6:0]       ptype_upd;
    logic [31:0]      ssrc_upd;
    logic [15:0]      ext_upd;
    logic             too_long_upd;
    logic [6:0]       hdr_bytes;
    logic [POS_W-1:0] ext_hi_pos;
    logic [POS_W-1:0] ext_lo_pos;

    assign hdr_bytes  = 7'(BASE_HDR_BYTES) + {1'b0, first_reg[3:0], 2'b00};
    assign ext_hi_pos = {{(POS_W-7){1'b0}}, hdr_bytes} + POS_W'(EXT_LEN_HI_OFS);
    assign ext_lo_pos = {{(POS_W-7){1'b0}}, hdr_bytes} + POS_W'(EXT_LEN_LO_OFS);

    // Capture header fields as their bytes go by
    always_comb begin
        first_upd    = (pos_reg == '0) ? pkt_byte : first_reg;
        ptype_upd    = (pos_reg == POS_W'(1)) ? pkt_byte[6:0] : ptype_reg;
        ssrc_upd     = ssrc_reg;
        ext_upd      = ext_reg;
        too_long_upd = too_long_reg | (pos_reg >= POS_W'(MAX_PACKET_BYTES));
        if (pos_reg >= POS_W'(SSRC_FIRST_POS) && pos_reg <= POS_W'(SSRC_LAST_POS)) begin
            ssrc_upd = {ssrc_reg[23:0], pkt_byte};
        end
        if (pos_reg == ext_hi_pos) begin
            ext_upd = {pkt_byte, ext_reg[7:0]};
        end
        if (pos_reg == ext_lo_pos) begin
            ext_upd = {ext_reg[15:8], pkt_byte};
        end
    end

    always_comb begin
        pos_next      = pos_reg;
        first_next    = first_reg;
        ptype_next    = ptype_reg;
        ssrc_next     = ssrc_reg;
        ext_next      = ext_reg;
        too_long_next = too_long_reg;
        if (byte_acc) begin
            if (end_of_packet) begin
                pos_next      = '0;
                first_next    = '0;
                ptype_next    = '0;
                ssrc_next     = '0;
                ext_next      = '0;
                too_long_next = 1'b0;
            end else begin
                pos_next      = (pos_reg == POS_MAX) ? pos_reg : pos_reg + POS_W'(1);
                first_next    = first_upd;
                ptype_next    = ptype_upd;
                ssrc_next     = ssrc_upd;
                ext_next      = ext_upd;
                too_long_next = too_long_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            first_reg    <= '0;
            ptype_reg    <= '0;
            ssrc_reg     <= '0;
            ext_reg      <= '0;
            too_long_reg <= 1'b0;
        end else begin
            pos_reg      <= pos_next;
            first_reg    <= first_next;
            ptype_reg    <= ptype_next;
            ssrc_reg     <= ssrc_next;
            ext_reg      <= ext_next;
            too_long_reg <= too_long_next;
        end
    end

    assign push                = byte_acc & end_of_packet;
    assign push_data.size      = {1'b0, pos_reg} + SIZE_W'(1);
    assign push_data.too_long  = too_long_upd;
    assign push_data.first_byte = first_upd;
    assign push_data.ptype     = ptype_upd;
    assign push_data.ssrc      = ssrc_upd;
    assign push_data.ext_words = ext_upd;
    assign push_data.last_byte = pkt_byte;
    assign push_data.aead_mode = aead_mode;

endmodule

// ----- rtl/rtpmhp_queue.sv -----
module rtpmhp_queue (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  rtpmhp_pkg::summary_t    push_data,
    input  logic                    pop,
    output rtpmhp_pkg::summary_t    head_data,
    output rtpmhp_pkg::queue_stat_t stat
);
    import rtpmhp_pkg::*;

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

    summary_t         entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + (PTR_W+1)'(1);
            2'b01:   count_next = count_reg - (PTR_W+1)'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head_data  = entry_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

// ----- rtl/rtpmhp_back.sv -----
module rtpmhp_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 head_valid,
    input  rtpmhp_pkg::summary_t head_data,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rtpmhp_pkg::result_t  out_data
);
    import rtpmhp_pkg::*;

    typedef struct packed {
        logic              bad_fixed;
        logic              ctrl;
        logic [HDR_W-1:0]  hdr;
        logic [6:0]        aad;
        logic [17:0]       ext;
        logic [SIZE_W-1:0] size;
        logic [31:0]       ssrc;
        logic              pad_en;
        logic [7:0]        pad;
    } stage1_t;

    typedef struct packed {
        logic        bad_fixed;
        logic        ctrl;
        logic        bad_len;
        logic [11:0] hdr;
        logic [11:0] payload;
        logic [6:0]  aad;
        logic [17:0] ext;
        logic [31:0] ssrc;
        logic        pad_en;
        logic [7:0]  pad;
    } stage2_t;

    logic    v1_reg, v1_next, v2_reg, v2_next, v3_reg, v3_next;
    logic    en1, en2, en3;
    stage1_t s1_reg, s1_next;
    stage2_t s2_reg, s2_next;
    result_t res_reg, res_next;

    logic [6:0]        hdr0;
    logic [17:0]       ext_bytes;
    logic [HDR_W-1:0]  hdr_add;
    logic              has_ext;
    logic [HDR_W:0]    len_diff;
    logic [12:0]       pad_diff;
    logic              pad_bad;
    logic              bad_late;

    // Elastic three-stage pipe: each stage loads when it is free or drains
    assign en3 = !v3_reg || out_ready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign pop = head_valid && en1;

    assign v1_next = en1 ? head_valid : v1_reg;
    assign v2_next = en2 ? v1_reg : v2_reg;
    assign v3_next = en3 ? v2_reg : v3_reg;

    // Stage 1: header end from CSRC count and extension
    always_comb begin
        has_ext   = head_data.first_byte[4];
        hdr0      = 7'(BASE_HDR_BYTES) + {1'b0, head_data.first_byte[3:0], 2'b00};
        ext_bytes = {head_data.ext_words, 2'b00};
        hdr_add   = '0;
        if (has_ext) begin
            hdr_add = head_data.aead_mode ? HDR_W'(EXT_HDR_BYTES)
                                          : HDR_W'(EXT_HDR_BYTES) + {1'b0, ext_bytes};
        end
        s1_next.bad_fixed = head_data.too_long
                          || head_data.size < SIZE_W'(MIN_PACKET_BYTES)
                          || head_data.first_byte[7:6] != RTP_VERSION;
        s1_next.ctrl   = head_data.ptype >= PT_CTRL_LO && head_data.ptype <= PT_CTRL_HI;
        s1_next.hdr    = {{(HDR_W-7){1'b0}}, hdr0} + hdr_add;
        s1_next.aad    = hdr0 + ((has_ext && head_data.aead_mode) ? 7'(EXT_HDR_BYTES) : 7'd0);
        s1_next.ext    = has_ext ? ext_bytes : '0;
        s1_next.size   = head_data.size;
        s1_next.ssrc   = head_data.ssrc;
        s1_next.pad_en = head_data.first_byte[5];
        s1_next.pad    = head_data.last_byte;
    end

    // Stage 2: payload before padding; a borrow means the header overruns
    always_comb begin
        len_diff = {{(HDR_W+1-SIZE_W){1'b0}}, s1_reg.size} - {1'b0, s1_reg.hdr};
        s2_next.bad_fixed = s1_reg.bad_fixed;
        s2_next.ctrl      = s1_reg.ctrl;
        s2_next.bad_len   = len_diff[HDR_W];
        s2_next.hdr       = s1_reg.hdr[11:0];
        s2_next.payload   = len_diff[11:0];
        s2_next.aad       = s1_reg.aad;
        s2_next.ext       = s1_reg.ext;
        s2_next.ssrc      = s1_reg.ssrc;
        s2_next.pad_en    = s1_reg.pad_en;
        s2_next.pad       = s1_reg.pad;
    end

    // Stage 3: strip padding and form the result
    always_comb begin
        pad_diff = {1'b0, s2_reg.payload} - {5'b0, s2_reg.pad};
        pad_bad  = s2_reg.pad_en && (s2_reg.payload == '0 || s2_reg.pad == '0 || pad_diff[12]);
        bad_late = s2_reg.bad_len || pad_bad;
        res_next = '0;
        if (s2_reg.bad_fixed || (!s2_reg.ctrl && bad_late)) begin
            res_next.status = 1'b1;
        end else if (!s2_reg.ctrl) begin
            res_next.media_ok        = 1'b1;
            res_next.payload_offset  = s2_reg.hdr;
            res_next.payload_length  = s2_reg.pad_en ? pad_diff[11:0] : s2_reg.payload;
            res_next.aad_length      = s2_reg.aad;
            res_next.ext_body_length = s2_reg.ext;
            res_next.sync_source     = s2_reg.ssrc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            s1_reg <= s1_next;
        end
        if (en2) begin
            s2_reg <= s2_next;
        end
        if (en3) begin
            res_reg <= res_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = res_reg;

endmodule

// ----- rtl/rtp_media_header_parser.sv -----
// A packet's summary is queued at its last byte, then passes the back-end pipeline.
// Throughput: one byte per cycle while the queue has room; one result per packet.
// s_tready drops only while the 2-entry packet queue is full (the result side stalled).
// Reset: synchronous, active-low aresetn clears the byte counter, captured header
// fields, queue pointers, pipeline valids and the AEAD mode register.
module rtp_media_header_parser (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,    // rtpsize_aead_mode
    // packet byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,        // [7:0] pkt_byte
    input  logic        s_tlast,        // end_of_packet
    // parse results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata         // [0] status, [1] media_ok,
                                        // [13:2] payload_offset, [25:14] payload_length,
                                        // [32:26] aad_length, [50:33] ext_body_length,
                                        // [82:51] sync_source, [87:83] zero
);
    import rtpmhp_pkg::*;

    logic        aead_mode_reg, aead_mode_next;
    logic        byte_acc;
    logic        push;
    logic        pop;
    summary_t    push_data;
    summary_t    head_data;
    queue_stat_t q_stat;
    result_t     res;

    // Config register: the user must write it only while the parser is idle; not enforced here
    assign aead_mode_next = cfg_wr_en ? cfg_wr_data : aead_mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            aead_mode_reg <= 1'b0;
        end else begin
            aead_mode_reg <= aead_mode_next;
        end
    end

    // Front end takes a word every cycle unless the queue is full
    assign s_tready = !q_stat.full;
    assign byte_acc = s_tvalid && s_tready;

    // Byte front end: track position, capture header fields, summarize at last byte
    rtpmhp_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .byte_acc      (byte_acc),
        .pkt_byte      (s_tdata),
        .end_of_packet (s_tlast),
        .aead_mode     (aead_mode_reg),
        .push          (push),
        .push_data     (push_data)
    );

    // Short queue that decouples byte intake from result back-pressure
    rtpmhp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head_data (head_data),
        .stat      (q_stat)
    );

    // Back end: validate the summary in three registered steps
    rtpmhp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (!q_stat.empty),
        .head_data  (head_data),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (res)
    );

    // Pack the result word, first field in the low bits
    assign m_tdata = {5'b0, res.sync_source, res.ext_body_length, res.aad_length,
                      res.payload_length, res.payload_offset, res.media_ok,
                      res.status};

`ifndef SYNTHESIS
    // An invalid packet reports every other field as zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[82:1] == '0)
        else $error("invalid result carries nonzero fields");

    // A decodable payload never starts inside the authenticated header
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1] |-> m_tdata[13:2] >= {5'b0, m_tdata[32:26]})
        else $error("payload offset below aad length");

    // A completed packet always lands in the queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        byte_acc && s_tlast |=> !q_stat.empty)
        else $error("packet summary lost at queue");

    // No result leaves right after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");
`endif

endmodule

// ----- sim/rtp_media_header_parser_checker.sv -----
module rtp_media_header_parser_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [87:0] m_tdata,
    output int          mismatches,
    output int          pending_results,
    output int          results_seen
);
    timeunit 1ns;
    timeprecision 1ps;
    import rtpmhp_pkg::*;

    localparam logic [7:0] EXT_FLAG = 8'h10;
    localparam logic [7:0] PAD_FLAG = 8'h20;
    localparam logic [7:0] CC_MASK  = 8'h0F;

    logic             aead_mode;
    logic [POS_W-1:0] byte_idx;
    logic [7:0]       lead_byte;
    logic [6:0]       pt_code;
    logic [31:0]      ssrc_shift;
    logic [15:0]      ext_len_words;
    logic             oversize;
    result_t          expected_headers[$];

    initial begin
        mismatches      = 0;
        pending_results = 0;
        results_seen    = 0;
    end

    task automatic clear_packet();
        byte_idx      = '0;
        lead_byte     = '0;
        pt_code       = '0;
        ssrc_shift    = '0;
        ext_len_words = '0;
        oversize      = 1'b0;
    endtask

    task automatic compare_field(input string name, input longint unsigned want,
                                 input longint unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endtask

    // Track one accepted byte; on the last byte of a packet queue its parse result
    task automatic track_rtp_byte(input logic [7:0] b, input logic eop);
        int unsigned pos, hdr, size, aad, ext, pay;
        logic        ok;
        result_t     r;
        pos = 32'(byte_idx);
        if (pos >= MAX_PACKET_BYTES)
            oversize = 1'b1;
        if (pos == 0)
            lead_byte = b;
        if (pos == 1)
            pt_code = b[6:0];
        if (pos >= SSRC_FIRST_POS && pos <= SSRC_LAST_POS)
            ssrc_shift = {ssrc_shift[23:0], b};
        // extension header sits right behind the CSRC list
        hdr = BASE_HDR_BYTES + int'(lead_byte & CC_MASK) * 4;
        if (pos == hdr + EXT_LEN_HI_OFS)
            ext_len_words[15:8] = b;
        if (pos == hdr + EXT_LEN_LO_OFS)
            ext_len_words[7:0] = b;
        if (byte_idx != POS_MAX)
            byte_idx++;
        if (!eop)
            return;

        size     = pos + 1;
        r        = '0;
        r.status = 1'b1;
        if (oversize || size < MIN_PACKET_BYTES || lead_byte[7:6] != RTP_VERSION) begin
            // drop: malformed
        end else if (pt_code >= PT_CTRL_LO && pt_code <= PT_CTRL_HI) begin
            r.status = 1'b0;            // control packet: pass, nothing to decode
        end else if (hdr <= size) begin
            ok  = 1'b1;
            aad = hdr;
            ext = 0;
            if ((lead_byte & EXT_FLAG) != 0) begin
                if (size - hdr < EXT_HDR_BYTES) begin
                    ok = 1'b0;
                end else begin
                    ext = int'(ext_len_words) * 4;
                    if (aead_mode) begin
                        // extension body rides along as payload
                        aad = hdr + EXT_HDR_BYTES;
                        hdr = aad;
                    end else begin
                        hdr = hdr + EXT_HDR_BYTES + ext;
                    end
                    if (hdr > size)
                        ok = 1'b0;
                end
            end
            if (ok) begin
                pay = size - hdr;
                if ((lead_byte & PAD_FLAG) != 0) begin
                    // last byte carries the pad count
                    if (pay == 0 || b == 0 || b > pay)
                        ok = 1'b0;
                    else
                        pay = pay - b;
                end
            end
            if (ok) begin
                r.status          = 1'b0;
                r.media_ok        = 1'b1;
                r.payload_offset  = hdr[11:0];
                r.payload_length  = pay[11:0];
                r.aad_length      = aad[6:0];
                r.ext_body_length = ext[17:0];
                r.sync_source     = ssrc_shift;
            end
        end
        expected_headers.push_back(r);
        clear_packet();
    endtask

    always @(posedge aclk) begin : monitor
        result_t want;
        if (!aresetn) begin
            aead_mode = 1'b0;
            clear_packet();
            expected_headers.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expected_headers.size() == 0) begin
                    mismatches++;
                    $display("%0t: result expected none, got 0x%h", $time, m_tdata);
                end else begin
                    want = expected_headers.pop_front();
                    compare_field("status", want.status, m_tdata[0]);
                    compare_field("media_ok", want.media_ok, m_tdata[1]);
                    compare_field("payload_offset", want.payload_offset, m_tdata[13:2]);
                    compare_field("payload_length", want.payload_length, m_tdata[25:14]);
                    compare_field("aad_length", want.aad_length, m_tdata[32:26]);
                    compare_field("ext_body_length", want.ext_body_length, m_tdata[50:33]);
                    compare_field("sync_source", want.sync_source, m_tdata[82:51]);
                end
            end
            if (s_tvalid && s_tready)
                track_rtp_byte(s_tdata, s_tlast);
            // mode register takes effect after this edge
            if (cfg_wr_en)
                aead_mode = cfg_wr_data;
        end
        pending_results = expected_headers.size();
    end

endmodule

// ----- sim/rtp_media_header_parser_tb.sv -----
module rtp_media_header_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rtpmhp_pkg::*;

    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         PHASE_BYTES    = 130;
    localparam logic [6:0] PT_MEDIA       = 7'd96;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic        cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [87:0] m_tdata;

    int mismatches;
    int pending_results;
    int results_seen;

    logic [7:0] pkt_q[$];      // bytes of the packet being sent
    int         bytes_sent;
    int         packets_sent;
    int         quiet_cycles;
    int         stall_left;
    bit         idle_on;

    rtp_media_header_parser uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    rtp_media_header_parser_checker parse_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatches      (mismatches),
        .pending_results (pending_results),
        .results_seen    (results_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Result side: hold off tready in random bursts while idling is on
    initial begin
        m_tready   = 1'b0;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (idle_on && stall_left == 0 && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 5);
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // End the run if no word moves on either side for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d idle cycles", quiet_cycles);
            $display("rtp_media_header_parser_tb NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one word and hold it until accepted; tready is sampled at the
    // falling edge so the decision never races the rising edge.
    task automatic push_byte(input logic [7:0] b, input logic eop);
        logic rdy;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eop;
        forever begin
            @(negedge aclk);
            rdy = s_tready;
            @(posedge aclk);
            if (rdy)
                break;
        end
        bytes_sent++;
    endtask

    // Stop sending, wait for every outstanding result, then let the pipe settle
    task automatic drain_results(input int settle);
        s_tvalid <= 1'b0;
        do
            @(negedge aclk);
        while (pending_results != 0);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic write_mode(input logic aead);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= aead;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Assemble a packet: fixed header, CSRC list, optional extension,
    // payload, then padding whose last byte is pad_val.
    task automatic build_packet(input logic [1:0] ver, input logic pbit, input logic xbit,
                                input logic [3:0] cc, input logic [6:0] pt,
                                input logic [15:0] ext_words, input int body_bytes,
                                input int pay_len, input int pad_len,
                                input logic [7:0] pad_val);
        pkt_q.delete();
        pkt_q.push_back({ver, pbit, xbit, cc});
        pkt_q.push_back({1'($urandom_range(0, 1)), pt});
        repeat (10 + 4 * cc) pkt_q.push_back(8'($urandom_range(0, 255)));
        if (xbit) begin
            repeat (2) pkt_q.push_back(8'($urandom_range(0, 255)));
            pkt_q.push_back(ext_words[15:8]);
            pkt_q.push_back(ext_words[7:0]);
            repeat (body_bytes) pkt_q.push_back(8'($urandom_range(0, 255)));
        end
        repeat (pay_len) pkt_q.push_back(8'($urandom_range(0, 255)));
        if (pad_len > 0) begin
            repeat (pad_len - 1) pkt_q.push_back(8'($urandom_range(0, 255)));
            pkt_q.push_back(pad_val);
        end
    endtask

    task automatic trim_packet(input int n);
        while (pkt_q.size() > n)
            void'(pkt_q.pop_back());
    endtask

    // Send the built packet; if cfg_at >= 0, stop before that byte, drain and
    // rewrite the mode so the change lands in the middle of the packet.
    task automatic send_packet(input int cfg_at, input logic aead);
        for (int i = 0; i < pkt_q.size(); i++) begin
            if (i == cfg_at) begin
                drain_results(4);
                write_mode(aead);
            end
            push_byte(pkt_q[i], i == pkt_q.size() - 1);
        end
        packets_sent++;
    endtask

    // Mostly well-formed packets with random content; the rest damaged,
    // cut short or pure noise.
    task automatic random_packet();
        int         kind, cc, pay, pad_len, ext_words, body;
        logic [1:0] ver;
        logic       pbit, xbit;
        logic [6:0] pt;
        logic [7:0] pad_val;
        kind = $urandom_range(0, 99);
        if (kind >= 90) begin
            pkt_q.delete();
            repeat ($urandom_range(1, 30)) pkt_q.push_back(8'($urandom_range(0, 255)));
        end else begin
            ver       = RTP_VERSION;
            cc        = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 2);
            xbit      = ($urandom_range(0, 2) == 0);
            pbit      = ($urandom_range(0, 3) == 0);
            pt        = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(PT_CTRL_LO, PT_CTRL_HI))
                                                    : 7'($urandom_range(0, 127));
            ext_words = $urandom_range(0, 3);
            body      = ext_words * 4;
            pay       = $urandom_range(0, 24);
            pad_len   = pbit ? $urandom_range(1, 8) : 0;
            pad_val   = 8'(pad_len);
            if (kind >= 70 && kind < 80) begin
                case ($urandom_range(0, 2))
                    0: pad_val = 8'($urandom_range(0, 255));
                    1: ver = 2'($urandom_range(0, 3));
                    default: ext_words = $urandom_range(0, 15);
                endcase
            end
            build_packet(ver, pbit, xbit, 4'(cc), pt, 16'(ext_words), body, pay, pad_len,
                         pad_val);
            if (kind >= 80)
                trim_packet(int'($urandom_range(1, pkt_q.size())));
        end
        send_packet(-1, 1'b0);
    endtask

    initial begin : stimulus
        logic [6:0] pt_corners[5];
        int         phase_start;
        bit         paused;
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        idle_on      = 1'b1;
        bytes_sent   = 0;
        packets_sent = 0;
        paused       = 1'b0;
        pt_corners   = '{PT_CTRL_LO, PT_CTRL_HI, PT_CTRL_LO - 7'd1, PT_CTRL_HI + 7'd1, 7'd127};

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: plain layout first
        write_mode(1'b0);
        build_packet(RTP_VERSION, 0, 0, 0, 0, 0, 0, 0, 0, 0);      // bare header
        send_packet(-1, 1'b0);
        build_packet(RTP_VERSION, 0, 0, 0, PT_MEDIA, 0, 0, 0, 0, 0);
        trim_packet(MIN_PACKET_BYTES - 1);                           // one byte short
        send_packet(-1, 1'b0);
        pkt_q = {8'hFF};                                             // lone byte
        send_packet(-1, 1'b0);
        build_packet(2'd3, 0, 0, 0, PT_MEDIA, 0, 0, 4, 0, 0);        // wrong version
        send_packet(-1, 1'b0);
        build_packet(2'd0, 0, 0, 0, PT_MEDIA, 0, 0, 4, 0, 0);
        send_packet(-1, 1'b0);
        foreach (pt_corners[i]) begin                                // control range edges
            build_packet(RTP_VERSION, 0, 0, 0, pt_corners[i], 0, 0, 5, 0, 0);
            send_packet(-1, 1'b0);
        end
        build_packet(RTP_VERSION, 0, 0, 15, PT_MEDIA, 0, 0, 3, 0, 0); // full CSRC list
        send_packet(-1, 1'b0);
        build_packet(RTP_VERSION, 0, 0, 15, PT_MEDIA, 0, 0, 0, 0, 0);
        trim_packet(40);                                             // CSRC list cut off
        send_packet(-1, 1'b0);
        build_packet(RTP_VERSION, 0, 1, 0, PT_MEDIA, 2, 8, 4, 0, 0);  // good extension
        send_packet(-1, 1'b0);
        build_packet(RTP_VERSION, 0, 1, 0, PT_MEDIA, 0, 0, 0, 0, 0);
        trim_packet(14);                                             // extension header cut
        send_packet(-1, 1'b0);
        build_packet(RTP_VERSION, 0, 1, 0, PT_MEDIA, 16'hFFFF, 8, 4, 0, 0); // body overrun
        send_packet(-1, 1'b0);
        build_packet(RTP_VERSION, 1, 0, 0, PT_MEDIA, 0, 0, 6, 3, 3);  // good padding
        send_packet(-1, 1'b0);
        build_packet(RTP_VERSION, 1, 0, 0, PT_MEDIA, 0, 0, 6, 3, 0);  // zero pad count
        send_packet(-1, 1'b0);
        build_packet(RTP_VERSION, 1, 0, 0, PT_MEDIA, 0, 0, 2, 1, 50); // pad beyond payload
        send_packet(-1, 1'b0);
        build_packet(RTP_VERSION, 1, 0, 0, PT_MEDIA, 0, 0, 0, 0, 0);  // padded, no payload
        send_packet(-1, 1'b0);

        // AEAD layout: extension body counts as payload
        drain_results(4);
        write_mode(1'b1);
        build_packet(RTP_VERSION, 0, 1, 0, PT_MEDIA, 16'hFFFF, 8, 4, 0, 0);
        send_packet(-1, 1'b0);
        build_packet(RTP_VERSION, 0, 1, 15, PT_MEDIA, 1, 4, 2, 0, 0); // largest auth header
        send_packet(-1, 1'b0);
        build_packet(RTP_VERSION, 1, 1, 0, PT_MEDIA, 3, 12, 0, 2, 2);
        send_packet(-1, 1'b0);
        // mode flips while a packet is halfway in
        build_packet(RTP_VERSION, 0, 1, 0, PT_MEDIA, 2, 8, 5, 0, 0);
        send_packet(6, 1'b0);
        build_packet(RTP_VERSION, 0, 1, 0, PT_MEDIA, 2, 8, 5, 0, 0);
        send_packet(9, 1'b1);

        // Random phases, mode rewritten between them; last phase runs without idling
        for (int ph = 0; ph < 6; ph++) begin
            drain_results(4);
            write_mode(ph < 2 ? 1'(ph % 2) : 1'($urandom_range(0, 1)));
            idle_on     = (ph < 5);
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) begin
                random_packet();
                if (ph == 2 && !paused && bytes_sent - phase_start > PHASE_BYTES / 2) begin
                    drain_results(1);
                    paused = 1'b1;
                end
            end
        end

        drain_results(8);
        $display("Sent %0d packets (%0d bytes), checked %0d results in both layouts:",
                 packets_sent, bytes_sent, results_seen);
        $display("  header, padding and extension corners, then random packets");
        if (mismatches == 0) begin
            $display("rtp_media_header_parser_tb OK");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("rtp_media_header_parser_tb NOT OK");
        end
        $finish;
    end

endmodule
